/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros shared by the frame parser RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define BMSFP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen on a rising clock edge outside reset.
`define BMSFP_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* hw/rtl/bmsfp_pkg.sv */
// ----------------------------------------------------------------------------
// bmsfp_pkg
// Types and constants shared by the battery-management frame parser.
// ----------------------------------------------------------------------------
package bmsfp_pkg;

    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEADER = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SUFFIX = CFG_IDX_W'(1);

    localparam logic [7:0] HEADER_RESET = 8'hDD;
    localparam logic [7:0] SUFFIX_RESET = 8'h77;

    typedef enum logic [2:0] {
        EV_HUNT    = 3'd0,
        EV_FIELD   = 3'd1,
        EV_PAYLOAD = 3'd2,
        EV_OK      = 3'd3,
        EV_STATUS  = 3'd4,
        EV_CKSUM   = 3'd5,
        EV_SUFFIX  = 3'd6
    } event_t;

    typedef struct packed {
        logic [7:0] header_byte;
        logic [7:0] suffix_byte;
    } cfg_t;

    typedef struct packed {
        event_t     ev;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic [7:0] command_id;
        logic [7:0] device_status;
        logic [7:0] payload_length;
    } result_t;

endpackage

/* hw/rtl/bmsfp_cfg.sv */
// ----------------------------------------------------------------------------
// bmsfp_cfg
// Configuration registers: header and suffix byte values.
// ----------------------------------------------------------------------------
module bmsfp_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bmsfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,
    output bmsfp_pkg::cfg_t                cfg
);
    import bmsfp_pkg::*;

    logic [7:0] header_reg;
    logic [7:0] suffix_reg;
    logic       wr_en;

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid && cfg_ready;

    // Writes to an index beyond the register list fall through and are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= HEADER_RESET;
            suffix_reg <= SUFFIX_RESET;
        end
        else if (wr_en)
        begin
            if (cfg_index == CFG_IDX_HEADER)
            begin
                header_reg <= cfg_data;
            end
            if (cfg_index == CFG_IDX_SUFFIX)
            begin
                suffix_reg <= cfg_data;
            end
        end
    end

    assign cfg.header_byte = header_reg;
    assign cfg.suffix_byte = suffix_reg;

endmodule

/* hw/rtl/bmsfp_core.sv */
// ----------------------------------------------------------------------------
// bmsfp_core
// Frame state machine: one received byte per beat, one result per byte.
// ----------------------------------------------------------------------------
module bmsfp_core (
    input  logic               clk,
    input  logic               rst_n,
    input  bmsfp_pkg::cfg_t    cfg,
    input  logic               byte_valid,
    input  logic [7:0]         rx_byte,
    output bmsfp_pkg::result_t res
);
    import bmsfp_pkg::*;

    `include "assert_macros.svh"

    typedef enum logic [7:0] {
        PH_HUNT    = 8'b0000_0001,
        PH_CMD     = 8'b0000_0010,
        PH_STATUS  = 8'b0000_0100,
        PH_LEN     = 8'b0000_1000,
        PH_PAYLOAD = 8'b0001_0000,
        PH_CK_HI   = 8'b0010_0000,
        PH_CK_LO   = 8'b0100_0000,
        PH_SUFFIX  = 8'b1000_0000
    } phase_t;

    phase_t      phase_reg,  phase_next;
    logic [7:0]  cmd_reg,    cmd_next;
    logic [7:0]  status_reg, status_next;
    logic [7:0]  length_reg, length_next;
    logic [7:0]  count_reg,  count_next;
    logic [15:0] sum_reg,    sum_next;

    event_t      ev;
    logic [7:0]  pbyte;
    logic [7:0]  pidx;
    logic [15:0] sum_add;
    logic [7:0]  count_inc;

    assign sum_add   = sum_reg + {8'd0, rx_byte};
    assign count_inc = count_reg + 8'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        cmd_next    = cmd_reg;
        status_next = status_reg;
        length_next = length_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        ev          = EV_HUNT;
        pbyte       = 8'd0;
        pidx        = 8'd0;

        unique case (phase_reg)
            PH_HUNT:
            begin
                if (rx_byte == cfg.header_byte)
                begin
                    cmd_next    = 8'd0;
                    status_next = 8'd0;
                    length_next = 8'd0;
                    count_next  = 8'd0;
                    sum_next    = 16'd0;
                    phase_next  = PH_CMD;
                    ev          = EV_FIELD;
                end
            end
            PH_CMD:
            begin
                cmd_next   = rx_byte;
                phase_next = PH_STATUS;
                ev         = EV_FIELD;
            end
            PH_STATUS:
            begin
                status_next = rx_byte;
                if (rx_byte != 8'd0)
                begin
                    phase_next = PH_HUNT;
                    ev         = EV_STATUS;
                end
                else
                begin
                    phase_next = PH_LEN;
                    ev         = EV_FIELD;
                end
            end
            PH_LEN:
            begin
                length_next = rx_byte;
                count_next  = 8'd0;
                ev          = EV_FIELD;
                // With no payload the negated sum is zero, so the sum simply clears.
                sum_next    = {8'd0, rx_byte};
                phase_next  = (rx_byte == 8'd0) ? PH_CK_HI : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                pbyte      = rx_byte;
                pidx       = count_reg;
                ev         = EV_PAYLOAD;
                count_next = count_inc;
                if (count_inc == length_reg)
                begin
                    sum_next   = ~sum_add + 16'd1;
                    phase_next = PH_CK_HI;
                end
                else
                begin
                    sum_next = sum_add;
                end
            end
            PH_CK_HI:
            begin
                if (rx_byte == sum_reg[15:8])
                begin
                    phase_next = PH_CK_LO;
                    ev         = EV_FIELD;
                end
                else
                begin
                    phase_next = PH_HUNT;
                    ev         = EV_CKSUM;
                end
            end
            PH_CK_LO:
            begin
                if (rx_byte == sum_reg[7:0])
                begin
                    phase_next = PH_SUFFIX;
                    ev         = EV_FIELD;
                end
                else
                begin
                    phase_next = PH_HUNT;
                    ev         = EV_CKSUM;
                end
            end
            PH_SUFFIX:
            begin
                ev         = (rx_byte == cfg.suffix_byte) ? EV_OK : EV_SUFFIX;
                phase_next = PH_HUNT;
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            cmd_reg    <= 8'd0;
            status_reg <= 8'd0;
            length_reg <= 8'd0;
            count_reg  <= 8'd0;
            sum_reg    <= 16'd0;
        end
        else if (byte_valid)
        begin
            phase_reg  <= phase_next;
            cmd_reg    <= cmd_next;
            status_reg <= status_next;
            length_reg <= length_next;
            count_reg  <= count_next;
            sum_reg    <= sum_next;
        end
    end

    assign res.ev             = ev;
    assign res.payload_byte   = pbyte;
    assign res.payload_index  = pidx;
    assign res.command_id     = cmd_next;
    assign res.device_status  = status_next;
    assign res.payload_length = length_next;

    `BMSFP_ASSERT(a_payload_count_in_range,
        (phase_reg == PH_PAYLOAD) |-> (count_reg < length_reg),
        "payload byte count reached the declared length inside the payload")
    `BMSFP_ASSERT(a_suffix_returns_to_hunt,
        (byte_valid && phase_reg == PH_SUFFIX) |=> (phase_reg == PH_HUNT),
        "parser did not return to hunting after the suffix byte")
    `BMSFP_ASSERT(a_hunt_event,
        (byte_valid && phase_reg == PH_HUNT) |=>
            ((phase_reg == PH_HUNT && cmd_reg == $past(cmd_reg)) ||
             (phase_reg == PH_CMD && cmd_reg == 8'd0 && sum_reg == 16'd0)),
        "a byte taken while hunting changed the held frame fields")

endmodule

/* hw/rtl/bmsfp_skid.sv */
// ----------------------------------------------------------------------------
// bmsfp_skid
// Output register with a skid entry, so a beat can be taken while the
// previous result is stalled.
// ----------------------------------------------------------------------------
module bmsfp_skid (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_stall,
    input  bmsfp_pkg::result_t push_data,
    output logic               pop_valid,
    input  logic               pop_stall,
    output bmsfp_pkg::result_t pop_data
);
    import bmsfp_pkg::*;

    `include "assert_macros.svh"

    result_t main_reg;
    result_t skid_reg;
    logic    main_valid_reg;
    logic    skid_valid_reg;
    logic    push_take;
    logic    pop_take;

    assign push_stall = skid_valid_reg;
    assign push_take  = push_valid && !push_stall;
    assign pop_take   = main_valid_reg && !pop_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push_take)
        begin
            if (main_valid_reg && !pop_take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
        else if (pop_take)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    // The payload registers carry no reset; only the valid flags matter.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop_take)
            begin
                main_reg <= skid_reg;
            end
        end
        else if (push_take)
        begin
            if (main_valid_reg && !pop_take)
            begin
                skid_reg <= push_data;
            end
            else
            begin
                main_reg <= push_data;
            end
        end
    end

    assign pop_valid = main_valid_reg;
    assign pop_data  = main_reg;

    `BMSFP_NEVER(a_skid_without_main,
        skid_valid_reg && !main_valid_reg,
        "skid entry holds a result while the output register is empty")
    `BMSFP_ASSERT(a_push_into_skid,
        (push_take && main_valid_reg && !pop_take) |=> skid_valid_reg,
        "a beat taken against a stalled output was not kept in the skid entry")
    `BMSFP_ASSERT(a_skid_drains_on_pop,
        (skid_valid_reg && pop_take) |=>
            (!skid_valid_reg && main_valid_reg && main_reg == $past(skid_reg)),
        "skid entry did not move into the output register")

endmodule

/* hw/rtl/bms_uart_frame_parser.sv */
// ----------------------------------------------------------------------------
// bms_uart_frame_parser
// Byte-serial parser for battery-management response frames.
// ----------------------------------------------------------------------------
// Takes one received byte per beat and returns exactly one result per byte
// from an output register. A new byte can be taken every cycle while in_stall
// is low: the frame state machine updates in the same cycle that it takes the
// byte, and a two-entry output buffer (output register plus skid entry) lets
// one more byte in while the output side stalls; in_stall rises only when both
// entries hold results. Header and suffix byte values are written through the
// configuration port while no byte is in flight; the user must ensure this.
module bms_uart_frame_parser (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bmsfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                      cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      rx_byte,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [2:0]                      event_res,
    output logic [7:0]                      payload_byte,
    output logic [7:0]                      payload_index,
    output logic [7:0]                      command_id,
    output logic [7:0]                      device_status,
    output logic [7:0]                      payload_length
);
    import bmsfp_pkg::*;

    cfg_t    cfg;
    result_t core_res;
    result_t out_res;
    logic    byte_take;

    assign byte_take = in_valid && !in_stall;

    bmsfp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bmsfp_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .byte_valid (byte_take),
        .rx_byte    (rx_byte),
        .res        (core_res)
    );

    bmsfp_skid u_skid (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_stall (in_stall),
        .push_data  (core_res),
        .pop_valid  (out_valid),
        .pop_stall  (out_stall),
        .pop_data   (out_res)
    );

    assign event_res      = 3'(out_res.ev);
    assign payload_byte   = out_res.payload_byte;
    assign payload_index  = out_res.payload_index;
    assign command_id     = out_res.command_id;
    assign device_status  = out_res.device_status;
    assign payload_length = out_res.payload_length;

endmodule
